>>> rtl/iwa_pkg.sv
// Shared constants for the interval window average block.
`timescale 1ns / 1ps
`default_nettype none
package iwa_pkg;

   localparam int FUNC_W        = 2;
   localparam int TIME_W        = 32;
   localparam int AVG_W         = 40;
   localparam int COUNT_W       = 7;
   localparam int FRAC_W        = 8;
   localparam int MAX_SLOTS_DEF = 64;
   localparam int WINDOW_RESET  = 16;

   // event codes
   localparam logic [FUNC_W-1:0] FN_START = 2'd0;
   localparam logic [FUNC_W-1:0] FN_END   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_NEXT  = 2'd2;

endpackage
`default_nettype wire

>>> rtl/iwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module iwa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/interval_window_average_core.sv
// Interval profiler: ring of measurement slots and windowed average.
//
// req_ channel takes one event item (func, now) at a time; every item gives
// exactly one rsp_ item (average_ticks, slot_count, logging).
// csr_ channel writes window_size whenever the block is idle; zero is
// ignored, values above MAX_SLOTS saturate.
// Slots live in a single RAM with registered read; an end or next event
// may run a short read-modify-write sequence, and an event that leaves two
// or more slots runs a restoring divider, one quotient bit per cycle.
// An accepted item passes S_DIV_INIT and S_DONE, with S_DIV between them
// when two or more slots are held afterwards. An end that closes an
// interval adds S_CLOSE; a next event adds the close and push states and
// an S_TRIM, S_TRIM_SUB pair for each slot trimmed from the window.
// One item is worked on at a time; the next item is taken as soon as the
// previous result sits in the output register, even if rsp_ready is low,
// but never before the previous item is done.
// If a result is still waiting when the next one is done, the sequencer
// holds until rsp_ready frees the output register.
// Sync reset: window min(16, MAX_SLOTS), no slots, interval closed, no result.
// Slot RAM contents need no clearing: every slot read was written by a push.
`timescale 1ns / 1ps
`default_nettype none
module interval_window_average_core #(
   parameter int MAX_SLOTS = iwa_pkg::MAX_SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [iwa_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [iwa_pkg::TIME_W-1:0]    req_now,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [iwa_pkg::AVG_W-1:0]     rsp_average_ticks,
   output logic      [iwa_pkg::COUNT_W-1:0]   rsp_slot_count,
   output logic                               rsp_logging,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [iwa_pkg::COUNT_W-1:0]   csr_window_size
);
   import iwa_pkg::*;

   localparam int AW     = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int SUM_W  = TIME_W + $clog2(MAX_SLOTS);
   localparam int DIV_W  = SUM_W + FRAC_W;
   localparam int DCNT_W = $clog2(DIV_W + 1);
   localparam int WIN_RST = (WINDOW_RESET > MAX_SLOTS) ? MAX_SLOTS : WINDOW_RESET;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLOSE,
      S_PUSH_CHK,
      S_DROP_FULL,
      S_PUSH_ADD,
      S_PUSH_WR,
      S_TRIM,
      S_TRIM_SUB,
      S_DIV_INIT,
      S_DIV,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic                open_ff, open_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  window_ff, window_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [DIV_W-1:0]    quot_ff, quot_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]    rsp_avg_ff, rsp_avg_in;
   logic [COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_log_ff, rsp_log_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [TIME_W-1:0]   ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [TIME_W-1:0]   ram_rdata;

   logic [CNT_W-1:0]    held_m1;
   logic [AW:0]         tail_sum;
   logic [AW-1:0]       tail_addr;
   logic [TIME_W-1:0]   elapsed;
   logic [TIME_W:0]     acc;
   logic [CNT_W:0]      rem_sh;
   logic [CNT_W:0]      div_by;
   logic                held_full;
   logic                over_window;
   logic                req_take;

   iwa_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // oldest slot sits held-1 entries after the front in ring order
   assign held_m1   = held_ff - CNT_W'(1);
   assign tail_sum  = {1'b0, head_ff} + {1'b0, held_m1[AW-1:0]};
   assign tail_addr = (tail_sum >= (AW+1)'(MAX_SLOTS)) ?
                      AW'(tail_sum - (AW+1)'(MAX_SLOTS)) : tail_sum[AW-1:0];

   assign elapsed     = now_ff - start_ff;
   assign acc         = {1'b0, ram_rdata} + {1'b0, elapsed};
   assign held_full   = 32'(held_ff) >= 32'(MAX_SLOTS);
   assign over_window = 32'(held_ff) > 32'(window_ff);
   assign rem_sh      = {rem_ff, quot_ff[DIV_W-1]};
   assign div_by      = {1'b0, held_m1};

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      start_in     = start_ff;
      head_in      = head_ff;
      held_in      = held_ff;
      sum_in       = sum_ff;
      window_in    = window_ff;
      func_in      = func_ff;
      now_in       = now_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_log_in   = rsp_log_ff;
      ram_we       = 1'b0;
      ram_waddr    = head_ff;
      ram_wdata    = '0;
      ram_raddr    = head_ff;

      if (csr_valid && csr_ready && csr_window_size != '0) begin
         window_in = (32'(csr_window_size) > 32'(MAX_SLOTS)) ?
                     COUNT_W'(MAX_SLOTS) : csr_window_size;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in  = req_func;
               now_in   = req_now;
               state_in = S_DIV_INIT;
               case (req_func)
                  FN_START: begin
                     if (!open_ff) begin
                        open_in  = 1'b1;
                        start_in = req_now;
                     end
                  end
                  FN_END, FN_NEXT: begin
                     open_in = 1'b0;
                     if (open_ff && held_ff != '0) begin
                        state_in = S_CLOSE;     // front slot read is in flight
                     end else if (req_func == FN_NEXT) begin
                        state_in = S_PUSH_CHK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CLOSE: begin
            ram_we    = 1'b1;
            ram_wdata = acc[TIME_W] ? '1 : acc[TIME_W-1:0];
            state_in  = (func_ff == FN_NEXT) ? S_PUSH_CHK : S_DIV_INIT;
         end
         S_PUSH_CHK: begin
            if (held_full) begin
               ram_raddr = tail_addr;
               state_in  = S_DROP_FULL;
            end else if (held_ff != '0) begin
               state_in = S_PUSH_ADD;
            end else begin
               state_in = S_PUSH_WR;
            end
         end
         S_DROP_FULL: begin
            sum_in   = sum_ff - SUM_W'(ram_rdata);
            held_in  = held_m1;
            state_in = S_PUSH_ADD;
         end
         S_PUSH_ADD: begin
            sum_in   = sum_ff + SUM_W'(ram_rdata);
            state_in = S_PUSH_WR;
         end
         S_PUSH_WR: begin
            head_in   = (head_ff == '0) ? AW'(MAX_SLOTS - 1) : head_ff - AW'(1);
            ram_we    = 1'b1;
            ram_waddr = head_in;
            held_in   = held_ff + CNT_W'(1);
            state_in  = S_TRIM;
         end
         S_TRIM: begin
            if (over_window) begin
               if (held_ff > CNT_W'(1)) begin
                  ram_raddr = tail_addr;
                  state_in  = S_TRIM_SUB;
               end else begin
                  held_in = held_m1;
               end
            end else begin
               state_in = S_DIV_INIT;
            end
         end
         S_TRIM_SUB: begin
            sum_in   = sum_ff - SUM_W'(ram_rdata);
            held_in  = held_m1;
            state_in = S_TRIM;
         end
         S_DIV_INIT: begin
            if (held_ff > CNT_W'(1)) begin
               quot_in  = {sum_ff, {FRAC_W{1'b0}}};
               rem_in   = '0;
               dcnt_in  = DCNT_W'(DIV_W);
               state_in = S_DIV;
            end else begin
               quot_in  = '0;
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rem_sh >= div_by) begin
               rem_in  = CNT_W'(rem_sh - div_by);
               quot_in = {quot_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[CNT_W-1:0];
               quot_in = {quot_ff[DIV_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = quot_ff[AVG_W-1:0];
               rsp_cnt_in   = COUNT_W'(held_ff);
               rsp_log_in   = open_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= 1'b0;
         start_ff     <= '0;
         head_ff      <= '0;
         held_ff      <= '0;
         sum_ff       <= '0;
         window_ff    <= COUNT_W'(WIN_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         start_ff     <= start_in;
         head_ff      <= head_in;
         held_ff      <= held_in;
         sum_ff       <= sum_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff    <= func_in;
      now_ff     <= now_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      dcnt_ff    <= dcnt_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_log_ff <= rsp_log_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average_ticks = rsp_avg_ff;
   assign rsp_slot_count    = rsp_cnt_ff;
   assign rsp_logging       = rsp_log_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      32'(held_ff) <= 32'(MAX_SLOTS))
      else $error("slot count exceeds ring depth");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < 32'(MAX_SLOTS))
      else $error("front pointer out of ring");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != S_IDLE)
      else $error("sequencer did not start on accepted item");

   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cnt_ff < COUNT_W'(2)) |-> rsp_avg_ff == '0)
      else $error("nonzero average with fewer than two slots");

endmodule
`default_nettype wire
